>>> rtl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/sflr_pkg.sv
// Shared constants, types and helpers of the stereo linear resampler.
// Used by the lane, merge and top-level modules; depends on nothing.
package sflr_pkg;

	localparam int SAMP_W  = 24;
	localparam int STEP_W  = 35;
	localparam int WORK_W  = 36;
	localparam int FRAC_W  = 32;
	localparam int MAX_OUT = 8;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;

	localparam logic [STEP_W-1:0] FRAME_ONE = STEP_W'(64'h1_0000_0000);

	localparam logic [2:0] REG_PHASE_STEP = 3'd0;
	localparam logic [2:0] REG_BYPASS     = 3'd1;
	localparam logic [2:0] REG_IN_WIDE    = 3'd2;
	localparam logic [2:0] REG_IN_MONO    = 3'd3;
	localparam logic [2:0] REG_OUT_WIDE   = 3'd4;
	localparam logic [2:0] REG_OUT_MONO   = 3'd5;

	typedef struct packed {
		logic wide;
		logic mono;
	} ofmt_t;

	// A 16-bit sample is taken from the low half and moved to the top of 24 bits.
	function automatic logic [SAMP_W-1:0] widen(input logic [SAMP_W-1:0] raw,
		input logic wide);
		if (wide) begin
			return raw;
		end
		return {raw[15:0], 8'h00};
	endfunction

endpackage

>>> rtl/sflr_lane.sv
// One channel lane: two-stage linear interpolation between two samples.
// Depends on sflr_pkg for widths.
module sflr_lane import sflr_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [SAMP_W-1:0] p,
	input  logic signed [SAMP_W-1:0] c,
	input  logic [FRAC_W-1:0]        frac,
	output logic signed [SAMP_W-1:0] y
);

	logic signed [SAMP_W:0]              diff;
	logic signed [SAMP_W+FRAC_W+1:0]     prod_s1;
	logic signed [SAMP_W-1:0]            p_s1;
	logic signed [SAMP_W+1:0]            step;
	logic signed [SAMP_W+1:0]            sum;
	logic signed [SAMP_W-1:0]            y_s2;

	assign diff = {c[SAMP_W-1], c} - {p[SAMP_W-1], p};
	assign step = prod_s1[SAMP_W+FRAC_W+1:FRAC_W];
	assign sum  = {{2{p_s1[SAMP_W-1]}}, p_s1} + step;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff * $signed({1'b0, frac});
			p_s1    <= p;
			y_s2    <= sum[SAMP_W-1:0];
		end
	end

	assign y = y_s2;

endmodule

>>> rtl/sflr_merge.sv
// Merge stage: combines the two lane results into mono or stereo and
// formats them to 24 bits or rounded 16 bits. Depends on sflr_pkg.
module sflr_merge import sflr_pkg::*; (
	input  logic signed [SAMP_W-1:0] l,
	input  logic signed [SAMP_W-1:0] r,
	input  ofmt_t                    fmt,
	output logic signed [SAMP_W-1:0] lo,
	output logic signed [SAMP_W-1:0] ro
);

	function automatic logic [SAMP_W-1:0] fmt_sample(input logic [SAMP_W-1:0] x,
		input logic wide);
		logic [SAMP_W:0] t;
		logic [16:0]     q;
		logic [15:0]     s;
		t = {x[SAMP_W-1], x} + (SAMP_W+1)'(128);
		q = t[SAMP_W:8];
		if (q[16] != q[15]) begin
			s = q[16] ? 16'h8000 : 16'h7FFF;
		end else begin
			s = q[15:0];
		end
		if (wide) begin
			return x;
		end
		return {{(SAMP_W-16){s[15]}}, s};
	endfunction

	logic [SAMP_W:0]   s;
	logic [SAMP_W:0]   sa;
	logic [SAMP_W-1:0] avg;
	logic [SAMP_W-1:0] a_in;
	logic [SAMP_W-1:0] b_in;

	// The average rounds toward zero, so a negative odd sum is nudged up first.
	assign s    = {l[SAMP_W-1], l} + {r[SAMP_W-1], r};
	assign sa   = s + (SAMP_W+1)'(s[SAMP_W] & s[0]);
	assign avg  = sa[SAMP_W:1];
	assign a_in = fmt.mono ? avg : l;
	assign b_in = fmt.mono ? avg : r;
	assign lo   = fmt_sample(a_in, fmt.wide);
	assign ro   = fmt_sample(b_in, fmt.wide);

endmodule

>>> rtl/stereo_format_linear_resampler.sv
// Stereo linear resampler: one frame per item, zero to eight results per item.
// An item is taken when the sequencer is idle; it then issues one point per cycle while
// the output is not stalled. Each issued point passes through the lane stages and the
// output register before its result is valid.
// The phase sequencer sets the rate; output stalls freeze the whole pipeline.
// Reset (arst_n low) clears control state and restores the register defaults.
`include "assert_macros.svh"

module stereo_format_linear_resampler import sflr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [SAMP_W-1:0] left_in,
	input  logic signed [SAMP_W-1:0] right_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [SAMP_W-1:0] left_out,
	output logic signed [SAMP_W-1:0] right_out,
	output logic                     last
);

	logic [STEP_W-1:0] phase_step_q;
	logic              bypass_q;
	logic              in_wide_q;
	logic              in_mono_q;
	logic              out_wide_q;
	logic              out_mono_q;

	logic              busy_q;
	logic              byp_job_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORK_W-1:0] work_q;
	logic [STEP_W-1:0] phase_q;
	logic              have_prev_q;
	logic [SAMP_W-1:0] prev_l_q;
	logic [SAMP_W-1:0] prev_r_q;
	logic [SAMP_W-1:0] pl_q;
	logic [SAMP_W-1:0] pr_q;
	logic [SAMP_W-1:0] cl_q;
	logic [SAMP_W-1:0] cr_q;

	logic              v_s1, v_s2, lst_s1, lst_s2;
	logic              out_valid_q;
	logic              last_q;
	logic [SAMP_W-1:0] left_q;
	logic [SAMP_W-1:0] right_q;

	logic              wr;
	logic              accept;
	logic              adv;
	logic              issue;
	logic              pt_last;
	logic [FRAC_W-1:0] pt_frac;
	logic [WORK_W-1:0] next_acc;
	logic [CNT_W-1:0]  cnt_nx;
	logic [SAMP_W-1:0] cl;
	logic [SAMP_W-1:0] cr;
	logic [SAMP_W-1:0] lane_l;
	logic [SAMP_W-1:0] lane_r;
	logic [SAMP_W-1:0] mrg_l;
	logic [SAMP_W-1:0] mrg_r;
	ofmt_t             fmt;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= FRAME_ONE;
			bypass_q     <= 1'b1;
			in_wide_q    <= 1'b1;
			in_mono_q    <= 1'b0;
			out_wide_q   <= 1'b1;
			out_mono_q   <= 1'b0;
		end else if (wr) begin
			case (paddr[5:3])
				REG_PHASE_STEP: phase_step_q <= pwdata[STEP_W-1:0];
				REG_BYPASS:     bypass_q     <= pwdata[0];
				REG_IN_WIDE:    in_wide_q    <= pwdata[0];
				REG_IN_MONO:    in_mono_q    <= pwdata[0];
				REG_OUT_WIDE:   out_wide_q   <= pwdata[0];
				REG_OUT_MONO:   out_mono_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[5:3])
			REG_PHASE_STEP: prdata = DATA_W'(phase_step_q);
			REG_BYPASS:     prdata = DATA_W'(bypass_q);
			REG_IN_WIDE:    prdata = DATA_W'(in_wide_q);
			REG_IN_MONO:    prdata = DATA_W'(in_mono_q);
			REG_OUT_WIDE:   prdata = DATA_W'(out_wide_q);
			REG_OUT_MONO:   prdata = DATA_W'(out_mono_q);
			default:        prdata = '0;
		endcase
	end

	assign cl       = widen(left_in, in_wide_q);
	assign cr       = in_mono_q ? cl : widen(right_in, in_wide_q);
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign adv      = !out_valid_q || out_ready;
	assign issue    = busy_q && adv;
	assign next_acc = work_q + {1'b0, phase_step_q};
	assign cnt_nx   = cnt_q + CNT_W'(1);
	assign pt_frac  = byp_job_q ? '0 : work_q[FRAC_W-1:0];
	assign pt_last  = byp_job_q || (cnt_nx == CNT_W'(MAX_OUT)) ||
		(next_acc[WORK_W-1:FRAC_W] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			byp_job_q   <= 1'b0;
			cnt_q       <= '0;
			work_q      <= '0;
			phase_q     <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= 1'b1;
			byp_job_q   <= bypass_q;
			cnt_q       <= '0;
			work_q      <= {1'b0, phase_q};
			if (bypass_q) begin
				busy_q <= 1'b1;
			end else if (phase_q[STEP_W-1:FRAC_W] != '0) begin
				busy_q  <= 1'b0;
				phase_q <= phase_q - FRAME_ONE;
			end else begin
				busy_q <= 1'b1;
			end
		end else if (issue) begin
			cnt_q  <= cnt_nx;
			work_q <= next_acc;
			if (pt_last) begin
				busy_q <= 1'b0;
				if (!byp_job_q) begin
					if (next_acc[WORK_W-1:FRAC_W] != '0) begin
						phase_q <= STEP_W'(next_acc - {1'b0, FRAME_ONE});
					end else begin
						phase_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_l_q <= cl;
			prev_r_q <= cr;
			cl_q     <= cl;
			cr_q     <= cr;
			pl_q     <= (bypass_q || !have_prev_q) ? cl : prev_l_q;
			pr_q     <= (bypass_q || !have_prev_q) ? cr : prev_r_q;
		end
	end

	sflr_lane u_lane_l (
		.clk  (clk),
		.en   (adv),
		.p    (pl_q),
		.c    (cl_q),
		.frac (pt_frac),
		.y    (lane_l)
	);

	sflr_lane u_lane_r (
		.clk  (clk),
		.en   (adv),
		.p    (pr_q),
		.c    (cr_q),
		.frac (pt_frac),
		.y    (lane_r)
	);

	assign fmt.wide = out_wide_q;
	assign fmt.mono = out_mono_q;

	sflr_merge u_merge (
		.l   (lane_l),
		.r   (lane_r),
		.fmt (fmt),
		.lo  (mrg_l),
		.ro  (mrg_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			lst_s1      <= 1'b0;
			lst_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			lst_s1      <= pt_last;
			v_s2        <= v_s1;
			lst_s2      <= lst_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_q  <= mrg_l;
			right_q <= mrg_r;
			last_q  <= lst_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;
	assign last      = last_q;

	`ASSERT_NXT(a_bypass_busy, clk, arst_n, accept && bypass_q, busy_q)
	`ASSERT_IMP(a_cnt_cap, clk, arst_n, busy_q, cnt_q < CNT_W'(MAX_OUT))
	`ASSERT_IMP(a_done_on_last, clk, arst_n, $fell(busy_q), $past(issue && pt_last))

endmodule
